// File: hdl/dmpid_pkg.sv
package dmpid_pkg;

  // field widths of the words and registers
  localparam int unsigned ADC_W      = 10;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned BAND_W     = 10;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // number of valid position numbers for a go-to
  localparam int unsigned POSITION_COUNT = 16;

  // internal arithmetic widths
  localparam int unsigned ERR_W    = ADC_W + 1;
  localparam int unsigned DERR_W   = ERR_W + 1;
  localparam int unsigned PPROD_W  = GAIN_W + ERR_W;
  localparam int unsigned DPROD_W  = GAIN_W + DERR_W;
  // |gain_d * derr| < 2^15 * 2^(DERR_W-1)
  localparam int unsigned DMAG_W   = (GAIN_W - 1) + (DERR_W - 1);
  localparam int unsigned INTEG_W  = 32;
  // gain fraction of 1024 and duty scaling are both a 10 bit shift
  localparam int unsigned FRAC_SH  = 10;
  localparam int unsigned DUTY_SH  = 10;

  // register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = '1;
  localparam logic [BAND_W-1:0]    BAND_RST    = BAND_W'(4);

  // opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_GOTO = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_MAX_DUTY0,
    REG_MAX_DUTY1,
    REG_TIMEOUT,
    REG_ARRIVE_BAND
  } cfg_reg_t;

  typedef struct packed {
    logic              opcode;
    logic [ADC_W-1:0]  adc_sample;
    logic [ADC_W-1:0]  target_position;
    logic [IDX_W-1:0]  target_index;
  } in_word_t;

  typedef struct packed {
    logic              direction;
    logic [DUTY_W-1:0] duty;
    logic              arrived;
    logic [IDX_W-1:0]  arrived_index;
  } out_word_t;

  // per-tick sideband carried down the pipeline
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    arrived;
    logic [IDX_W-1:0]        idx;
  } side_t;

  // duty limits and integral gain sign seen by the drive loop
  typedef struct packed {
    logic              ki_pos;
    logic [DUTY_W-1:0] max_duty0;
    logic [DUTY_W-1:0] max_duty1;
  } duty_lim_t;

endpackage

// File: hdl/dmpid_ddiv.sv
module dmpid_ddiv #(
  parameter int unsigned TICK_PERIOD_MS = 10,
  parameter int unsigned DQ_W           = 33
) (
  input  logic                                  clk,
  input  logic                                  en_pp,
  input  logic                                  en_q,
  input  logic signed [dmpid_pkg::DPROD_W-1:0]  prod,
  output logic                                  neg,
  output logic [DQ_W-1:0]                       quot
);
  import dmpid_pkg::*;

  // floor(|prod| * 1024 / T) as one reciprocal multiply
  localparam int unsigned NUM_W = DMAG_W + FRAC_SH;
  localparam int unsigned LOG_T = $clog2(TICK_PERIOD_MS);
  localparam int unsigned RSH   = NUM_W + LOG_T;
  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(TICK_PERIOD_MS) - 64'd1) / 64'(TICK_PERIOD_MS);
  localparam int unsigned M_W    = NUM_W + 1;
  localparam int unsigned LO_W   = (M_W + 1) / 2;
  localparam int unsigned HI_W   = M_W - LO_W;
  localparam int unsigned FULL_W = DMAG_W + M_W;
  localparam int unsigned QSH    = RSH - FRAC_SH;
  localparam logic [M_W-1:0] M   = M_W'(RECIP);

  logic [DPROD_W-1:0]     prod_abs;
  logic [DMAG_W-1:0]      mag;
  logic [DMAG_W+LO_W-1:0] pp_lo_r;
  logic [DMAG_W+HI_W-1:0] pp_hi_r;
  logic                   neg_pp_r;
  logic [FULL_W-1:0]      full;
  logic [DQ_W-1:0]        quot_r;
  logic                   neg_r;

  // magnitude of the derivative product
  assign prod_abs = prod[DPROD_W-1] ? (~$unsigned(prod) + 1'b1) : $unsigned(prod);
  assign mag      = prod_abs[DMAG_W-1:0];

  // partial products of the reciprocal multiply
  always_ff @(posedge clk) begin
    if (en_pp) begin
      pp_lo_r  <= mag * M[LO_W-1:0];
      pp_hi_r  <= mag * M[M_W-1:LO_W];
      neg_pp_r <= prod[DPROD_W-1];
    end
  end

  // combine and shift down to the quotient
  assign full = (FULL_W'(pp_hi_r) << LO_W) + FULL_W'(pp_lo_r);

  always_ff @(posedge clk) begin
    if (en_q) begin
      quot_r <= full[QSH +: DQ_W];
      neg_r  <= neg_pp_r;
    end
  end

  assign quot = quot_r;
  assign neg  = neg_r;

endmodule

// File: hdl/dmpid_loop.sv
module dmpid_loop #(
  parameter int unsigned KIT_W = 20,
  parameter int unsigned PD_W  = 35
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic signed [dmpid_pkg::ERR_W-1:0]   err,
  input  logic signed [PD_W-1:0]               pd,
  input  logic signed [KIT_W-1:0]              ki_t,
  input  dmpid_pkg::duty_lim_t                 lim,
  output logic                                 dir,
  output logic [dmpid_pkg::DUTY_W-1:0]         duty
);
  import dmpid_pkg::*;

  localparam int unsigned IP_W     = KIT_W + INTEG_W;
  localparam int unsigned IT_W     = IP_W - FRAC_SH;
  localparam int unsigned DRV_W    = ((PD_W > IT_W) ? PD_W : IT_W) + 1;
  localparam int unsigned MAG_HI_W = DRV_W - DUTY_SH;

  logic signed [INTEG_W-1:0] integ_r, integ_nxt, integ_sat;
  logic signed [INTEG_W:0]   isum;
  logic                      dir_r, dir_nxt;
  logic [DUTY_W-1:0]         duty_r, duty_nxt;
  logic                      hold;
  logic signed [IP_W-1:0]    ip, ip_b;
  logic signed [IT_W-1:0]    it;
  logic signed [DRV_W-1:0]   drive;
  logic                      drv_neg;
  logic [DRV_W-1:0]          mag;
  logic [MAG_HI_W-1:0]       mag_hi;
  logic [DUTY_W-1:0]         ceil_duty;

  // anti-windup: freeze the integrator while pinned at the ceiling
  always_comb begin
    if (dir_r) begin
      hold = (duty_r == lim.max_duty1) && (lim.ki_pos == (err > 0));
    end else begin
      hold = (duty_r == lim.max_duty0) && (lim.ki_pos == err[ERR_W-1]);
    end
  end

  // saturating integrator update
  always_comb begin
    isum = (INTEG_W + 1)'(integ_r) + (INTEG_W + 1)'(err);
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      integ_sat = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end
    integ_nxt = hold ? integ_r : integ_sat;
  end

  // integral term, truncated toward zero, then total drive
  always_comb begin
    ip      = ki_t * integ_nxt;
    ip_b    = ip + $signed(IP_W'({FRAC_SH{ip[IP_W-1]}}));
    it      = ip_b[IP_W-1:FRAC_SH];
    drive   = DRV_W'(pd) + DRV_W'(it);
    drv_neg = drive[DRV_W-1];
    mag     = drv_neg ? DRV_W'(-drive) : DRV_W'(drive);
  end

  // direction and clamped duty
  always_comb begin
    mag_hi    = mag[DRV_W-1:DUTY_SH];
    ceil_duty = drv_neg ? lim.max_duty0 : lim.max_duty1;
    dir_nxt   = ~drv_neg;
    if (mag_hi > MAG_HI_W'(ceil_duty)) begin
      duty_nxt = ceil_duty;
    end else begin
      duty_nxt = mag_hi[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      dir_r   <= 1'b0;
      duty_r  <= '0;
    end else if (en) begin
      integ_r <= integ_nxt;
      dir_r   <= dir_nxt;
      duty_r  <= duty_nxt;
    end
  end

  assign dir  = dir_r;
  assign duty = duty_r;

endmodule

// File: hdl/dc_motor_position_pid_top.sv
// Position PID for one potentiometer-fed DC motor. A go-to word sets the target and the
// position number and starts a move; it returns no result. A tick word carries one ADC
// sample and returns one result word (direction, duty, arrival flag and index) after
// stages a to e and the result register. The block takes one word per clock cycle
// while the result side does not stall, a rate set by the integrator and drive loop in
// the last stage around one integral-gain multiply. The derivative scaling by 1024 / tick
// period runs ahead in a two-stage reciprocal multiply. No pass over memory after reset.
module dc_motor_position_pid_top #(
  parameter int unsigned TICK_PERIOD_MS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dmpid_pkg::in_word_t                 in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dmpid_pkg::out_word_t                out_word,
  input  logic                                cfg_we,
  input  logic [dmpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmpid_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dmpid_pkg::*;

  // widths that follow from the tick period
  localparam int unsigned TP_W  = $clog2(TICK_PERIOD_MS + 1);
  localparam int unsigned KIT_W = GAIN_W + TP_W;
  localparam int unsigned LOG_T = $clog2(TICK_PERIOD_MS);
  localparam longint unsigned DQ_MAX =
    (((64'd1 << DMAG_W) - 64'd1) << FRAC_SH) / 64'(TICK_PERIOD_MS);
  localparam int unsigned DQ_W  = $clog2(DQ_MAX + 64'd1);
  localparam int unsigned PD_W  = ((PPROD_W > DQ_W + 1) ? PPROD_W : DQ_W + 1) + 1;

  // timeout / tick period by reciprocal multiply
  localparam int unsigned TL_S  = TIMEOUT_W + LOG_T;
  localparam int unsigned TL_MW = TIMEOUT_W + 1;
  localparam int unsigned TL_PW = TIMEOUT_W + TL_MW;
  localparam longint unsigned TL_RECIP =
    ((64'd1 << TL_S) + 64'(TICK_PERIOD_MS) - 64'd1) / 64'(TICK_PERIOD_MS);
  localparam longint unsigned TL_MAX =
    ((64'd1 << TIMEOUT_W) - 64'd1) / 64'(TICK_PERIOD_MS);
  localparam int unsigned TL_W  = $clog2(TL_MAX + 64'd1);
  localparam logic [TL_MW-1:0] TL_M   = TL_MW'(TL_RECIP);
  localparam logic [TL_W-1:0]  TL_RST = TL_W'(TL_MAX);

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic signed [KIT_W-1:0]  ki_t_r, ki_t_nxt;
  logic [DUTY_W-1:0]        max0_r, max1_r;
  logic [TL_W-1:0]          to_lim_r, to_lim_nxt;
  logic [BAND_W-1:0]        band_r;
  logic [TL_PW-1:0]         tl_prod;

  // tracking state
  logic [ADC_W-1:0]         goal_r, goal_nxt;
  logic [IDX_W-1:0]         gidx_r, gidx_nxt;
  logic [TIMEOUT_W-1:0]     elapsed_r, elapsed_nxt, elapsed_inc;
  logic                     moving_r, moving_nxt;
  logic signed [ERR_W-1:0]  last_err_r, last_err_nxt;

  // front stage logic
  logic                     a_fire, is_tick, goto_ok, done;
  logic signed [ERR_W-1:0]  err_nxt;
  logic [ERR_W-1:0]         err_abs;
  logic [ADC_W-1:0]         err_mag;
  logic signed [DERR_W-1:0] derr;
  logic signed [PPROD_W-1:0] pp_nxt;
  logic signed [DPROD_W-1:0] dp_nxt;
  side_t                    side_nxt;

  // pipeline registers
  logic                     a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, out_vld_r;
  logic                     rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_out;
  in_word_t                 a_r;
  side_t                    b_side_r, c_side_r, d_side_r, e_side_r;
  logic signed [PPROD_W-1:0] b_pp_r, c_pp_r, d_pp_r;
  logic signed [DPROD_W-1:0] b_dp_r;
  logic signed [PD_W-1:0]   e_pd_r, pd_nxt, dq_s;
  logic                     d_neg;
  logic [DQ_W-1:0]          d_q;
  logic                     out_arr_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic                     loop_en, drv_dir;
  logic [DUTY_W-1:0]        drv_duty;
  duty_lim_t                lim;

  // derived register values, taken at the write
  assign tl_prod    = cfg_data * TL_M;
  assign to_lim_nxt = tl_prod[TL_S +: TL_W];
  assign ki_t_nxt   = $signed(cfg_data) * $signed({1'b0, TP_W'(TICK_PERIOD_MS)});

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      ki_t_r   <= '0;
      max0_r   <= '0;
      max1_r   <= '0;
      to_lim_r <= TL_RST;
      band_r   <= BAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_P:      gain_p_r <= cfg_data;
        REG_GAIN_I: begin
          gain_i_r <= cfg_data;
          ki_t_r   <= ki_t_nxt;
        end
        REG_GAIN_D:      gain_d_r <= cfg_data;
        REG_MAX_DUTY0:   max0_r   <= cfg_data[DUTY_W-1:0];
        REG_MAX_DUTY1:   max1_r   <= cfg_data[DUTY_W-1:0];
        REG_TIMEOUT:     to_lim_r <= to_lim_nxt;
        REG_ARRIVE_BAND: band_r   <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // ready chain from the result side back to the input
  assign rdy_out  = ~out_vld_r | ~out_stall;
  assign rdy_e    = ~e_vld_r | rdy_out;
  assign rdy_d    = ~d_vld_r | rdy_e;
  assign rdy_c    = ~c_vld_r | rdy_d;
  assign rdy_b    = ~b_vld_r | rdy_c;
  assign rdy_a    = ~a_vld_r | rdy_b;
  assign in_stall = ~rdy_a;

  // front stage: error, arrival and move tracking
  always_comb begin
    a_fire      = a_vld_r & rdy_b;
    is_tick     = (a_r.opcode == OP_TICK);
    goto_ok     = (32'(a_r.target_index) < POSITION_COUNT);
    elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
    err_nxt     = $signed({1'b0, goal_r}) - $signed({1'b0, a_r.adc_sample});
    err_abs     = err_nxt[ERR_W-1] ? ERR_W'(-err_nxt) : ERR_W'(err_nxt);
    err_mag     = err_abs[ADC_W-1:0];
    done        = moving_r & ((err_mag < band_r) |
                              (elapsed_inc > TIMEOUT_W'(to_lim_r)));
    derr        = DERR_W'(err_nxt) - DERR_W'(last_err_r);
    pp_nxt      = gain_p_r * err_nxt;
    dp_nxt      = gain_d_r * derr;
    side_nxt.err     = err_nxt;
    side_nxt.arrived = done;
    side_nxt.idx     = done ? gidx_r : '0;
  end

  always_comb begin
    goal_nxt     = goal_r;
    gidx_nxt     = gidx_r;
    elapsed_nxt  = elapsed_r;
    moving_nxt   = moving_r;
    last_err_nxt = last_err_r;
    if (a_fire) begin
      if (is_tick) begin
        elapsed_nxt  = elapsed_inc;
        last_err_nxt = err_nxt;
        if (done) begin
          moving_nxt = 1'b0;
        end
      end else if (goto_ok) begin
        goal_nxt    = a_r.target_position;
        gidx_nxt    = a_r.target_index;
        elapsed_nxt = '0;
        moving_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r     <= '0;
      gidx_r     <= '0;
      elapsed_r  <= '0;
      moving_r   <= 1'b0;
      last_err_r <= '0;
    end else begin
      goal_r     <= goal_nxt;
      gidx_r     <= gidx_nxt;
      elapsed_r  <= elapsed_nxt;
      moving_r   <= moving_nxt;
      last_err_r <= last_err_nxt;
    end
  end

  // stage valids; go-to words stop after the front stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy_a)   a_vld_r   <= in_valid;
      if (rdy_b)   b_vld_r   <= a_vld_r & is_tick;
      if (rdy_c)   c_vld_r   <= b_vld_r;
      if (rdy_d)   d_vld_r   <= c_vld_r;
      if (rdy_e)   e_vld_r   <= d_vld_r;
      if (rdy_out) out_vld_r <= e_vld_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (rdy_a & in_valid) begin
      a_r <= in_word;
    end
    if (rdy_b) begin
      b_side_r <= side_nxt;
      b_pp_r   <= pp_nxt;
      b_dp_r   <= dp_nxt;
    end
    if (rdy_c) begin
      c_side_r <= b_side_r;
      c_pp_r   <= b_pp_r;
    end
    if (rdy_d) begin
      d_side_r <= c_side_r;
      d_pp_r   <= c_pp_r;
    end
    if (rdy_e) begin
      e_side_r <= d_side_r;
      e_pd_r   <= pd_nxt;
    end
    if (loop_en) begin
      out_arr_r <= e_side_r.arrived;
      out_idx_r <= e_side_r.idx;
    end
  end

  // derivative scaling, stages c and d
  dmpid_ddiv #(
    .TICK_PERIOD_MS (TICK_PERIOD_MS),
    .DQ_W           (DQ_W)
  ) u_ddiv (
    .clk   (clk),
    .en_pp (rdy_c),
    .en_q  (rdy_d),
    .prod  (b_dp_r),
    .neg   (d_neg),
    .quot  (d_q)
  );

  // proportional plus derivative
  assign dq_s   = PD_W'(d_q);
  assign pd_nxt = PD_W'(d_pp_r) + (d_neg ? -dq_s : dq_s);

  // integrator and drive, last stage into the result register
  assign loop_en       = e_vld_r & rdy_out;
  assign lim.ki_pos    = (gain_i_r > 0);
  assign lim.max_duty0 = max0_r;
  assign lim.max_duty1 = max1_r;

  dmpid_loop #(
    .KIT_W (KIT_W),
    .PD_W  (PD_W)
  ) u_loop (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (loop_en),
    .err   (e_side_r.err),
    .pd    (e_pd_r),
    .ki_t  (ki_t_r),
    .lim   (lim),
    .dir   (drv_dir),
    .duty  (drv_duty)
  );

  // result word
  assign out_valid              = out_vld_r;
  assign out_word.direction     = drv_dir;
  assign out_word.duty          = drv_duty;
  assign out_word.arrived       = out_arr_r;
  assign out_word.arrived_index = out_idx_r;

endmodule

// File: dv/tb_dc_motor_position_pid_top.sv
module tb_dc_motor_position_pid_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmpid_pkg::*;

  localparam int TICK_MS     = 10;
  localparam int GAIN_SCALE  = 1024;
  localparam int ADC_MAX     = (1 << ADC_W) - 1;
  localparam int TICKS_MAX   = (1 << TIMEOUT_W) - 1;
  localparam int LAT_PAD     = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 94;
  localparam int CYCLE_LIMIT = 400000;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  // register index past the end of the list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    in_word_t              w;
    bit                    typed;
    out_word_t             want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // loop model: registers
  int kp = 0, ki = 0, kd = 0;
  int cap0 = 0, cap1 = 0;
  int move_limit = TICKS_MAX;
  int band = 4;

  // loop model: state
  int integ = 0, prev_err = 0;
  bit dir_q = 1'b0;
  int duty_q = 0;
  bit in_motion = 1'b0;
  int ticks = 0;
  int goal_pos = 0, goal_idx = 0;

  out_word_t drive_due[$];
  out_word_t due_word;
  plan_row_t plan[$];

  int n_fail    = 0;
  int cycles    = 0;
  int snd_pct   = 0;
  int rcv_pct   = 0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  dc_motor_position_pid_top #(
    .TICK_PERIOD_MS(TICK_MS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < rcv_pct);
    end
  end

  // one tick or go-to through the position loop
  function automatic void step_position_loop(input in_word_t w, output bit made,
                                             output out_word_t r);
    int     err, err_abs, cap;
    longint acc, drive, mag;
    bit     ki_pos, hold, done;
    made = 1'b0;
    r    = '0;
    if (w.opcode == OP_GOTO) begin
      if (int'(w.target_index) < POSITION_COUNT) begin
        goal_pos  = int'(w.target_position);
        goal_idx  = int'(w.target_index);
        ticks     = 0;
        in_motion = 1'b1;
      end
      return;
    end
    if (ticks < TICKS_MAX) ticks++;
    err     = goal_pos - int'(w.adc_sample);
    err_abs = (err < 0) ? -err : err;
    // arrival or timeout, judged on this tick's error
    done = in_motion && (err_abs < band || ticks > move_limit / TICK_MS);
    if (done) in_motion = 1'b0;
    // anti-windup: no integration while pinned at the ceiling and pushing on
    ki_pos = ki > 0;
    if (dir_q) hold = (duty_q == cap1) && (ki_pos == (err > 0));
    else hold = (duty_q == cap0) && (ki_pos == (err < 0));
    if (!hold) begin
      acc = longint'(integ) + err;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      if (acc < INTEG_MIN) acc = INTEG_MIN;
      integ = int'(acc);
    end
    drive = longint'(kp) * err
          + (longint'(ki) * integ * TICK_MS) / GAIN_SCALE
          + (longint'(kd) * (err - prev_err) * GAIN_SCALE) / TICK_MS;
    prev_err = err;
    if (drive < 0) begin
      dir_q = 1'b0;
      mag   = -drive;
      cap   = cap0;
    end else begin
      dir_q = 1'b1;
      mag   = drive;
      cap   = cap1;
    end
    mag = mag >> DUTY_SH;
    if (mag > cap) mag = cap;
    duty_q = int'(mag);
    r.direction     = dir_q;
    r.duty          = duty_q[DUTY_W-1:0];
    r.arrived       = done;
    r.arrived_index = done ? goal_idx[IDX_W-1:0] : '0;
    made = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_fail++;
    end
  endfunction

  // result checking against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (drive_due.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_word);
        n_fail++;
      end else begin
        due_word = drive_due.pop_front();
        check_field("direction", 8'(due_word.direction), 8'(out_word.direction));
        check_field("duty", due_word.duty, out_word.duty);
        check_field("arrived", 8'(due_word.arrived), 8'(out_word.arrived));
        check_field("arrived_index", 8'(due_word.arrived_index),
                    8'(out_word.arrived_index));
      end
    end
  end

  // offer one word with random idle cycles ahead, return once it is taken
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    logic [31:0] junk;
    out_word_t   got;
    bit          made;
    @(negedge clk);
    while ($urandom_range(99, 0) < snd_pct) begin
      junk = $urandom;
      in_valid <= 1'b0;
      in_word  <= junk[$bits(in_word_t)-1:0];
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_position_loop(w, made, got);
    if (made) drive_due.push_back(typed ? want : got);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
  endtask

  // empty pipe: a trailing go-to may still be in flight
  task automatic settle();
    drain();
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:      kp = int'($signed(data));
      REG_GAIN_I:      ki = int'($signed(data));
      REG_GAIN_D:      kd = int'($signed(data));
      REG_MAX_DUTY0:   cap0 = int'(data[DUTY_W-1:0]);
      REG_MAX_DUTY1:   cap1 = int'(data[DUTY_W-1:0]);
      REG_TIMEOUT:     move_limit = int'(data[TIMEOUT_W-1:0]);
      REG_ARRIVE_BAND: band = int'(data[BAND_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_word(input logic op, input int adc, input int tgt,
                                   input int idx, input bit typed = 1'b0,
                                   input out_word_t want = '0);
    plan_row_t row;
    row.kind              = ROW_WORD;
    row.w.opcode          = op;
    row.w.adc_sample      = ADC_W'(adc);
    row.w.target_position = ADC_W'(tgt);
    row.w.target_index    = IDX_W'(idx);
    row.typed             = typed;
    row.want              = want;
    row.idx               = '0;
    row.data              = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row.kind  = ROW_REG;
    row.w     = '0;
    row.typed = 1'b0;
    row.want  = '0;
    row.idx   = idx;
    row.data  = data;
    plan.push_back(row);
  endfunction

  function automatic logic [15:0] rand_gain();
    int mag;
    case ($urandom_range(3, 0))
      0: return ($urandom_range(1, 0) != 0) ? 16'h7fff : 16'h8000;
      1: mag = $urandom_range(300, 0);
      2: mag = $urandom_range(4000, 0);
      default: return 16'($urandom);
    endcase
    return ($urandom_range(1, 0) != 0) ? 16'(-mag) : 16'(mag);
  endfunction

  initial begin
    in_word_t    w;
    logic [31:0] rnd;
    int          pos, aim, stride, jit, v, pick, c0, c1, tmo, bnd;

    // reset registers: zero gains and ceilings, so every duty is 0, direction 1
    add_word(OP_TICK, 0, ADC_MAX, 15, 1'b1, {1'b1, 8'd0, 1'b0, 4'd0});
    add_word(OP_TICK, ADC_MAX, 0, 0, 1'b1, {1'b1, 8'd0, 1'b0, 4'd0});
    add_word(OP_GOTO, 0, ADC_MAX, 15);
    add_word(OP_TICK, ADC_MAX, 0, 0, 1'b1, {1'b1, 8'd0, 1'b1, 4'd15});
    add_word(OP_TICK, 1020, 0, 0, 1'b1, {1'b1, 8'd0, 1'b0, 4'd0});
    add_word(OP_GOTO, ADC_MAX, 0, 0);
    add_word(OP_TICK, 4, ADC_MAX, 15, 1'b1, {1'b1, 8'd0, 1'b0, 4'd0});
    add_word(OP_TICK, 3, ADC_MAX, 15, 1'b1, {1'b1, 8'd0, 1'b1, 4'd0});
    // largest gains and ceilings, immediate timeout, no arrival band
    add_reg(REG_GAIN_P, 16'h7fff);
    add_reg(REG_GAIN_I, 16'h7fff);
    add_reg(REG_GAIN_D, 16'h7fff);
    add_reg(REG_MAX_DUTY0, 16'h00ff);
    add_reg(REG_MAX_DUTY1, 16'h00ff);
    add_reg(REG_TIMEOUT, 16'h0000);
    add_reg(REG_ARRIVE_BAND, 16'h0000);
    add_reg(REG_SPARE, 16'hffff);
    add_word(OP_GOTO, ADC_MAX, 512, 10);
    add_word(OP_TICK, 512, 0, 0);
    add_word(OP_TICK, 0, 0, 0);
    add_word(OP_TICK, 0, 0, 0);
    add_word(OP_TICK, ADC_MAX, 0, 0);
    add_word(OP_TICK, ADC_MAX, 0, 0);
    // most negative gains, widest band, junk above the narrow fields
    add_reg(REG_GAIN_P, 16'h8000);
    add_reg(REG_GAIN_I, 16'h8000);
    add_reg(REG_GAIN_D, 16'h8000);
    add_reg(REG_MAX_DUTY0, 16'hab00);
    add_reg(REG_TIMEOUT, 16'hffff);
    add_reg(REG_ARRIVE_BAND, 16'hffff);
    add_word(OP_GOTO, 0, 0, 5);
    add_word(OP_TICK, ADC_MAX, 0, 0);
    add_word(OP_TICK, 1022, 0, 0);
    add_word(OP_TICK, 0, 0, 0);
    add_word(OP_TICK, ADC_MAX, 0, 0);
    // modest gains, short timeout against a narrow band
    add_reg(REG_GAIN_P, 16'd200);
    add_reg(REG_GAIN_I, 16'd50);
    add_reg(REG_GAIN_D, -16'sd100);
    add_reg(REG_MAX_DUTY0, 16'd128);
    add_reg(REG_MAX_DUTY1, 16'd64);
    add_reg(REG_TIMEOUT, 16'd30);
    add_reg(REG_ARRIVE_BAND, 16'd2);
    add_word(OP_GOTO, 0, 300, 7);
    add_word(OP_TICK, 200, 0, 0);
    add_word(OP_TICK, 250, 0, 0);
    add_word(OP_TICK, 290, 0, 0);
    add_word(OP_TICK, 299, 0, 0);

    // synchronous reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each with its own register set and idling mix
    pos = $urandom_range(ADC_MAX, 0);
    aim = goal_pos;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      snd_pct = (phase % 4 == 1) ? 52 : (phase % 4 == 3) ? 24 : 0;
      rcv_pct = (phase % 4 == 2) ? 52 : (phase % 4 == 3) ? 24 : 0;
      case (phase)
        0: begin c0 = 255; c1 = 255; end
        1: begin c0 = 0; c1 = 0; end
        default: begin
          c0 = $urandom_range(255, 0);
          c1 = $urandom_range(255, 0);
        end
      endcase
      case ($urandom_range(3, 0))
        0: tmo = 0;
        1: tmo = TICKS_MAX;
        default: tmo = $urandom_range(400, 20);
      endcase
      case ($urandom_range(5, 0))
        0: bnd = 0;
        1: bnd = ADC_MAX;
        default: bnd = $urandom_range(30, 1);
      endcase
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, rand_gain());
      write_reg(REG_GAIN_D, rand_gain());
      write_reg(REG_MAX_DUTY0, {8'($urandom), 8'(c0)});
      write_reg(REG_MAX_DUTY1, {8'($urandom), 8'(c1)});
      write_reg(REG_TIMEOUT, 16'(tmo));
      write_reg(REG_ARRIVE_BAND, {6'($urandom), 10'(bnd)});
      write_reg(REG_SPARE, 16'($urandom));

      for (int k = 0; k < PHASE_WORDS; k++) begin
        // let the pipe back up against a stalled result side
        if (phase == 4 && k == 20) hold_req = 1'b1;
        // sender waits out every outstanding result
        if (phase == 6 && k == 50) drain();
        rnd  = $urandom;
        w    = rnd[$bits(in_word_t)-1:0];
        pick = $urandom_range(99, 0);
        if (pick < 12) begin
          w.opcode = OP_GOTO;
          aim      = int'(w.target_position);
        end else begin
          w.opcode = OP_TICK;
          // mostly a shaft creeping toward the goal, some noise samples
          if (pick >= 20) begin
            stride = $urandom_range(40, 0);
            if (pos + stride < aim) pos += stride;
            else if (pos > aim + stride) pos -= stride;
            else pos = aim;
            jit = int'($urandom_range(4, 0)) - 2;
            v   = pos + jit;
            if (v < 0) v = 0;
            if (v > ADC_MAX) v = ADC_MAX;
            w.adc_sample = ADC_W'(v);
          end
        end
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
